// ===== sv/dwg_pkg.sv =====
package dwg_pkg;

    localparam int GAMMA_TABLE_DEPTH = 1024;
    localparam int DEPTH_BITS        = 16;

    localparam int GAMMA_IDX_W = $clog2(GAMMA_TABLE_DEPTH);
    localparam int GAMMA_SHIFT = 16 - GAMMA_IDX_W;

    localparam int Z_W      = 16;
    localparam int RECIP_W  = 33;
    localparam int PROD_W   = Z_W + RECIP_W;
    localparam int NORM_W   = 17;
    localparam int TIDX_W   = 10;
    localparam int GRAY_W   = 8;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    localparam logic [Z_W-1:0]    DEPTH_MASK = Z_W'((32'd1 << DEPTH_BITS) - 32'd1);
    localparam logic [NORM_W-1:0] NORM_ONE   = 17'h10000;

    localparam logic [Z_W-1:0]     RST_DEPTH_MIN = 16'd0;
    localparam logic [Z_W-1:0]     RST_DEPTH_MAX = 16'hFFFF;
    localparam logic [RECIP_W-1:0] RST_RECIP     = 33'd65537;

    typedef enum logic [2:0] {
        REG_DEPTH_MIN  = 3'd0,
        REG_DEPTH_MAX  = 3'd1,
        REG_RECIP      = 3'd2,
        REG_INVERT     = 3'd3,
        REG_GAMMA      = 3'd4
    } reg_idx_t;

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_TABLE_WR = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [Z_W-1:0]     depth_min;
        logic [Z_W-1:0]     depth_max;
        logic [RECIP_W-1:0] range_reciprocal;
        logic               invert_enable;
        logic               gamma_enable;
    } cfg_t;

    typedef struct packed {
        opcode_t             op;
        logic                zero;
        logic [NORM_W-1:0]   n;
        logic [TIDX_W-1:0]   tidx;
        logic [GRAY_W-1:0]   tval;
    } norm_t;

endpackage

// ===== sv/dwg_cfg.sv =====
module dwg_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwg_pkg::APB_AW-1:0]  paddr,
    input  logic [dwg_pkg::APB_DW-1:0]  pwdata,
    output logic [dwg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output dwg_pkg::cfg_t               cfg
);

    dwg_pkg::cfg_t     cfg_reg;
    dwg_pkg::reg_idx_t idx;
    logic              wr;

    assign pready = 1'b1;
    assign idx    = dwg_pkg::reg_idx_t'(paddr[dwg_pkg::APB_AW-1:3]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_min        <= dwg_pkg::RST_DEPTH_MIN;
            cfg_reg.depth_max        <= dwg_pkg::RST_DEPTH_MAX;
            cfg_reg.range_reciprocal <= dwg_pkg::RST_RECIP;
            cfg_reg.invert_enable    <= 1'b0;
            cfg_reg.gamma_enable     <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                dwg_pkg::REG_DEPTH_MIN: cfg_reg.depth_min <= pwdata[dwg_pkg::Z_W-1:0];
                dwg_pkg::REG_DEPTH_MAX: cfg_reg.depth_max <= pwdata[dwg_pkg::Z_W-1:0];
                dwg_pkg::REG_RECIP:
                    cfg_reg.range_reciprocal <= pwdata[dwg_pkg::RECIP_W-1:0];
                dwg_pkg::REG_INVERT:    cfg_reg.invert_enable <= pwdata[0];
                dwg_pkg::REG_GAMMA:     cfg_reg.gamma_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            dwg_pkg::REG_DEPTH_MIN: prdata = dwg_pkg::APB_DW'(cfg_reg.depth_min);
            dwg_pkg::REG_DEPTH_MAX: prdata = dwg_pkg::APB_DW'(cfg_reg.depth_max);
            dwg_pkg::REG_RECIP:     prdata = dwg_pkg::APB_DW'(cfg_reg.range_reciprocal);
            dwg_pkg::REG_INVERT:    prdata = dwg_pkg::APB_DW'(cfg_reg.invert_enable);
            dwg_pkg::REG_GAMMA:     prdata = dwg_pkg::APB_DW'(cfg_reg.gamma_enable);
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== sv/dwg_norm.sv =====
module dwg_norm
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dwg_pkg::cfg_t               cfg,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  logic                        opcode,
    input  logic [dwg_pkg::Z_W-1:0]     depth,
    input  logic [dwg_pkg::TIDX_W-1:0]  table_index,
    input  logic [dwg_pkg::GRAY_W-1:0]  table_value,
    input  logic                        down_ready,
    output logic                        norm_valid,
    output dwg_pkg::norm_t              norm
);

    // stage 1: clamp and offset
    logic                          v1_reg;
    dwg_pkg::opcode_t              op1_reg;
    logic                          zero1_reg;
    logic [dwg_pkg::Z_W-1:0]       diff1_reg;
    logic [dwg_pkg::TIDX_W-1:0]    tidx1_reg;
    logic [dwg_pkg::GRAY_W-1:0]    tval1_reg;

    // stage 2: product
    logic                          v2_reg;
    dwg_pkg::opcode_t              op2_reg;
    logic                          zero2_reg;
    logic [dwg_pkg::PROD_W-1:0]    prod2_reg;
    logic [dwg_pkg::TIDX_W-1:0]    tidx2_reg;
    logic [dwg_pkg::GRAY_W-1:0]    tval2_reg;

    // stage 3: saturate and invert
    logic                          v3_reg;
    dwg_pkg::norm_t                n3_reg;
    dwg_pkg::norm_t                n3_next;

    logic                          adv1;
    logic                          adv2;
    logic                          adv3;
    logic [dwg_pkg::Z_W-1:0]       z;
    logic [dwg_pkg::Z_W-1:0]       zc;
    logic [dwg_pkg::Z_W-1:0]       diff1_next;
    logic [dwg_pkg::PROD_W-1:0]    prod2_next;
    logic [dwg_pkg::PROD_W-17:0]   q;
    logic [dwg_pkg::NORM_W-1:0]    nsat;

    assign adv3      = !v3_reg || down_ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign pix_stall = !adv1;

    assign norm_valid = v3_reg;
    assign norm       = n3_reg;

    always_comb
    begin
        z = depth & dwg_pkg::DEPTH_MASK;
        if (z < cfg.depth_min)
            zc = cfg.depth_min;
        else if (z > cfg.depth_max)
            zc = cfg.depth_max;
        else
            zc = z;
        diff1_next = zc - cfg.depth_min;
    end

    assign prod2_next = dwg_pkg::PROD_W'(diff1_reg) * dwg_pkg::PROD_W'(cfg.range_reciprocal);

    always_comb
    begin
        q = prod2_reg[dwg_pkg::PROD_W-1:16];
        if (q > (dwg_pkg::PROD_W-16)'(dwg_pkg::NORM_ONE))
            nsat = dwg_pkg::NORM_ONE;
        else
            nsat = q[dwg_pkg::NORM_W-1:0];
        n3_next.op   = op2_reg;
        n3_next.zero = zero2_reg;
        n3_next.n    = cfg.invert_enable ? (dwg_pkg::NORM_ONE - nsat) : nsat;
        n3_next.tidx = tidx2_reg;
        n3_next.tval = tval2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pix_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && pix_valid)
        begin
            op1_reg   <= dwg_pkg::opcode_t'(opcode);
            zero1_reg <= (cfg.depth_max <= cfg.depth_min);
            diff1_reg <= diff1_next;
            tidx1_reg <= table_index;
            tval1_reg <= table_value;
        end
        if (adv2 && v1_reg)
        begin
            op2_reg   <= op1_reg;
            zero2_reg <= zero1_reg;
            prod2_reg <= prod2_next;
            tidx2_reg <= tidx1_reg;
            tval2_reg <= tval1_reg;
        end
        if (adv3 && v2_reg)
            n3_reg <= n3_next;
    end

endmodule

// ===== sv/dwg_map.sv =====
module dwg_map
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dwg_pkg::cfg_t               cfg,
    input  logic                        norm_valid,
    input  dwg_pkg::norm_t              norm,
    output logic                        down_ready,
    output logic                        gray_valid,
    input  logic                        gray_stall,
    output logic [dwg_pkg::GRAY_W-1:0]  gray
);

    logic [dwg_pkg::GRAY_W-1:0]      gamma_mem [dwg_pkg::GAMMA_TABLE_DEPTH];

    logic                            v4_reg;
    logic                            zero4_reg;
    logic                            gam4_reg;
    logic [dwg_pkg::GRAY_W-1:0]      lin4_reg;
    logic [dwg_pkg::GRAY_W-1:0]      rd4_reg;

    logic                            take;
    logic                            is_conv;
    logic                            wr_ok;
    logic [31:0]                     widx;
    logic [dwg_pkg::GAMMA_IDX_W-1:0] ridx;
    logic [24:0]                     scaled;

    assign down_ready = !v4_reg || !gray_stall;
    assign take       = norm_valid && down_ready;
    assign is_conv    = (norm.op == dwg_pkg::OP_CONVERT);
    assign widx       = 32'(norm.tidx);
    assign wr_ok      = widx < 32'(dwg_pkg::GAMMA_TABLE_DEPTH);

    // full scale would land one past the last entry, so it maps to the last entry
    assign ridx   = norm.n[16] ? {dwg_pkg::GAMMA_IDX_W{1'b1}}
                               : dwg_pkg::GAMMA_IDX_W'(norm.n >> dwg_pkg::GAMMA_SHIFT);
    assign scaled = {norm.n, 8'd0} - 25'(norm.n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (down_ready)
            v4_reg <= norm_valid && is_conv;
    end

    always_ff @(posedge clk)
    begin
        if (take && !is_conv && wr_ok)
            gamma_mem[widx[dwg_pkg::GAMMA_IDX_W-1:0]] <= norm.tval;
        if (take && is_conv)
        begin
            rd4_reg   <= gamma_mem[ridx];
            zero4_reg <= norm.zero;
            gam4_reg  <= cfg.gamma_enable;
            lin4_reg  <= scaled[23:16];
        end
    end

    assign gray_valid = v4_reg;

    always_comb
    begin
        if (zero4_reg)
            gray = '0;
        else if (gam4_reg)
            gray = rd4_reg;
        else
            gray = lin4_reg;
    end

endmodule

// ===== sv/depth_window_to_gray_gamma.sv =====
// Channel   Signals                                         Direction
// pixel     pix_valid, pix_stall, opcode, depth,            in (stall out)
//           table_index, table_value
// gray      gray_valid, gray_stall, gray                    out (stall in)
// config    psel, penable, pwrite, paddr, pwdata,           APB, 8-byte regs
//           prdata, pready
//
// Four register stages: clamp/offset, 16x33 multiply, saturate/invert,
// gamma RAM read or linear scale. One transaction per cycle while no stall holds
// the pipe; converted pixels leave stage four on gray. Table writes land in stage four.
// Reset clears valid bits and config; the gamma RAM is not cleared.
// gray_stall holds every full stage; empty stages still fill.
module depth_window_to_gray_gamma
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwg_pkg::APB_AW-1:0]  paddr,
    input  logic [dwg_pkg::APB_DW-1:0]  pwdata,
    output logic [dwg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  logic                        opcode,
    input  logic [dwg_pkg::Z_W-1:0]     depth,
    input  logic [dwg_pkg::TIDX_W-1:0]  table_index,
    input  logic [dwg_pkg::GRAY_W-1:0]  table_value,
    output logic                        gray_valid,
    input  logic                        gray_stall,
    output logic [dwg_pkg::GRAY_W-1:0]  gray
);

    dwg_pkg::cfg_t  cfg;
    dwg_pkg::norm_t norm;
    logic           norm_valid;
    logic           down_ready;

    dwg_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dwg_norm u_norm
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .opcode      (opcode),
        .depth       (depth),
        .table_index (table_index),
        .table_value (table_value),
        .down_ready  (down_ready),
        .norm_valid  (norm_valid),
        .norm        (norm)
    );

    dwg_map u_map
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .norm_valid (norm_valid),
        .norm       (norm),
        .down_ready (down_ready),
        .gray_valid (gray_valid),
        .gray_stall (gray_stall),
        .gray       (gray)
    );

endmodule

// ===== tb/sv/gray_level_checker.sv =====
module gray_level_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwg_pkg::APB_AW-1:0]  paddr,
    input  logic [dwg_pkg::APB_DW-1:0]  pwdata,
    input  logic                        pready,
    input  logic                        pix_valid,
    input  logic                        pix_stall,
    input  logic                        opcode,
    input  logic [dwg_pkg::Z_W-1:0]     depth,
    input  logic [dwg_pkg::TIDX_W-1:0]  table_index,
    input  logic [dwg_pkg::GRAY_W-1:0]  table_value,
    input  logic                        gray_valid,
    input  logic                        gray_stall,
    input  logic [dwg_pkg::GRAY_W-1:0]  gray,
    output int                          mismatches,
    output int                          gray_owed
);
    import dwg_pkg::*;

    logic [Z_W-1:0]     win_min;
    logic [Z_W-1:0]     win_max;
    logic [RECIP_W-1:0] recip;
    logic               flip;
    logic               use_gamma;
    logic [GRAY_W-1:0]  curve [GAMMA_TABLE_DEPTH];
    logic [GRAY_W-1:0]  gray_due [$];
    logic [GRAY_W-1:0]  want;

    function automatic logic [GRAY_W-1:0] window_to_gray(logic [Z_W-1:0] raw);
        logic [Z_W-1:0]    z;
        logic [PROD_W-1:0] prod;
        logic [NORM_W-1:0] n;
        logic [31:0]       lin;
        int unsigned       slot;
        z = raw & DEPTH_MASK;
        if (win_max <= win_min)
            return '0;
        if (z < win_min)
            z = win_min;
        if (z > win_max)
            z = win_max;
        prod = PROD_W'(z - win_min) * PROD_W'(recip);
        prod = prod >> 16;
        n = (prod > PROD_W'(NORM_ONE)) ? NORM_ONE : NORM_W'(prod);
        if (flip)
            n = NORM_ONE - n;
        if (!use_gamma)
        begin
            lin = 32'(n) * 32'd255;
            return GRAY_W'(lin >> 16);
        end
        slot = (32'(n) * GAMMA_TABLE_DEPTH) >> 16;
        if (slot > GAMMA_TABLE_DEPTH - 1)
            slot = GAMMA_TABLE_DEPTH - 1;
        return curve[slot];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_min   = RST_DEPTH_MIN;
            win_max   = RST_DEPTH_MAX;
            recip     = RST_RECIP;
            flip      = 1'b0;
            use_gamma = 1'b0;
            gray_due.delete();
            mismatches <= 0;
            gray_owed  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_AW-1:3]))
                    REG_DEPTH_MIN: win_min   = pwdata[Z_W-1:0];
                    REG_DEPTH_MAX: win_max   = pwdata[Z_W-1:0];
                    REG_RECIP:     recip     = pwdata[RECIP_W-1:0];
                    REG_INVERT:    flip      = pwdata[0];
                    REG_GAMMA:     use_gamma = pwdata[0];
                    default: ;
                endcase
            end
            if (gray_valid && !gray_stall)
            begin
                if (gray_due.size() == 0)
                begin
                    $error("gray: unexpected transaction, actual %0d", gray);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = gray_due.pop_front();
                    if (gray !== want)
                    begin
                        $error("gray: expected %0d actual %0d", want, gray);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (pix_valid && !pix_stall)
            begin
                if (opcode_t'(opcode) == OP_TABLE_WR)
                begin
                    if (int'(table_index) < GAMMA_TABLE_DEPTH)
                        curve[table_index] = table_value;
                end
                else
                    gray_due.push_back(window_to_gray(depth));
            end
            gray_owed <= gray_due.size();
        end
    end

endmodule

// ===== tb/sv/depth_window_to_gray_gamma_test.sv =====
module depth_window_to_gray_gamma_test;
    import dwg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 200;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                pix_valid   = 1'b0;
    logic                pix_stall;
    logic                opcode      = 1'b0;
    logic [Z_W-1:0]      depth       = '0;
    logic [TIDX_W-1:0]   table_index = '0;
    logic [GRAY_W-1:0]   table_value = '0;
    logic                gray_valid;
    logic                gray_stall  = 1'b0;
    logic [GRAY_W-1:0]   gray;

    int mismatches;
    int gray_owed;
    int cycle_count = 0;
    int tx_idle_pct = 25;
    int rx_idle_pct = 20;
    bit calm        = 1'b0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    logic [Z_W-1:0] cur_min = RST_DEPTH_MIN;
    logic [Z_W-1:0] cur_max = RST_DEPTH_MAX;

    depth_window_to_gray_gamma dut (.*);

    gray_level_checker chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // gray receiver: long hold on request, otherwise random stall bursts
    always
    begin
        @(posedge clk);
        if (hold_req)
        begin
            gray_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            gray_stall <= 1'b0;
            hold_req = 1'b0;
        end
        else if (!calm && !quiet && $urandom_range(99) < rx_idle_pct)
        begin
            gray_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clk);
            gray_stall <= 1'b0;
        end
    end

    task automatic offer(opcode_t op, logic [Z_W-1:0] dep, logic [TIDX_W-1:0] idx,
                         logic [GRAY_W-1:0] val);
        if (!calm && $urandom_range(99) < tx_idle_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pix_valid   <= 1'b1;
        opcode      <= op;
        depth       <= dep;
        table_index <= idx;
        table_value <= val;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
    endtask

    task automatic send_pixel(logic [Z_W-1:0] dep);
        offer(OP_CONVERT, dep, TIDX_W'($urandom), GRAY_W'($urandom));
    endtask

    task automatic send_entry(logic [TIDX_W-1:0] idx, logic [GRAY_W-1:0] val);
        offer(OP_TABLE_WR, Z_W'($urandom), idx, val);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (gray_owed != 0) @(posedge clk);
        quiet = 1'b1;
        repeat (SETTLE) @(posedge clk);
        quiet = 1'b0;
    endtask

    task automatic write_reg(reg_idx_t r, logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic configure(logic [Z_W-1:0] mn, logic [Z_W-1:0] mx, logic [63:0] rc,
                             logic inv, logic gam);
        wait_drained();
        write_reg(REG_DEPTH_MIN, APB_DW'(mn));
        write_reg(REG_DEPTH_MAX, APB_DW'(mx));
        write_reg(REG_RECIP, APB_DW'(rc));
        write_reg(REG_INVERT, APB_DW'(inv));
        write_reg(REG_GAMMA, APB_DW'(gam));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_min = mn;
        cur_max = mx;
    endtask

    function automatic logic [63:0] exact_recip(logic [Z_W-1:0] mn, logic [Z_W-1:0] mx);
        return (64'd1 << 32) / 64'(mx - mn);
    endfunction

    function automatic logic [Z_W-1:0] pick_depth();
        int base;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: base = int'(cur_min) + int'($urandom_range(6)) - 3;
            4, 5: base = int'(cur_max) + int'($urandom_range(6)) - 3;
            default: return Z_W'($urandom);
        endcase
        if (base < 0)
            base = 0;
        if (base > 65535)
            base = 65535;
        return Z_W'(base);
    endfunction

    task automatic random_config();
        logic [Z_W-1:0] mn;
        logic [Z_W-1:0] mx;
        logic [Z_W-1:0] tmp;
        logic [63:0]    rc;
        mn = Z_W'($urandom);
        mx = Z_W'($urandom);
        case ($urandom_range(9))
            0: mx = mn;
            1: ;
            2:
            begin
                mn = '0;
                mx = '1;
            end
            3:
            begin
                mn = Z_W'($urandom_range(0, 65000));
                mx = mn + Z_W'($urandom_range(1, 40));
            end
            default:
            begin
                if (mn > mx)
                begin
                    tmp = mn;
                    mn  = mx;
                    mx  = tmp;
                end
            end
        endcase
        if (mx > mn)
        begin
            rc = exact_recip(mn, mx);
            case ($urandom_range(7))
                0: rc = rc + 64'($urandom_range(1, 5000));
                1: rc = 64'd1 << 32;
                2: rc = '0;
                default: ;
            endcase
            if (rc > (64'd1 << 32))
                rc = 64'd1 << 32;
        end
        else
            rc = 64'($urandom);
        configure(mn, mx, rc, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: full range, linear, no invert
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);

        configure(16'd0, 16'hFFFF, 64'd65537, 1'b1, 1'b0);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);

        // clamp below and above a narrow window
        configure(16'd1000, 16'd5000, exact_recip(16'd1000, 16'd5000), 1'b0, 1'b0);
        send_pixel(16'd0);
        send_pixel(16'd1000);
        send_pixel(16'd3000);
        send_pixel(16'd5000);
        send_pixel(16'hFFFF);

        // empty windows
        configure(16'd7000, 16'd7000, 64'd65537, 1'b0, 1'b0);
        send_pixel(16'd7000);
        configure(16'hFFFF, 16'd0, 64'd1 << 32, 1'b1, 1'b0);
        send_pixel(16'd100);

        // reciprocal overshoot and zero reciprocal
        configure(16'd0, 16'd100, 64'd1 << 32, 1'b0, 1'b0);
        send_pixel(16'd50);
        send_pixel(16'd100);
        configure(16'd0, 16'd100, 64'd0, 1'b1, 1'b0);
        send_pixel(16'd50);

        // load every gamma entry before any lookup
        for (int i = 0; i < GAMMA_TABLE_DEPTH; i++)
            send_entry(TIDX_W'(i), GRAY_W'($urandom));

        configure(16'd0, 16'hFFFF, 64'd65537, 1'b0, 1'b1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_entry(TIDX_W'(GAMMA_TABLE_DEPTH - 1), GRAY_W'($urandom));
        send_pixel(16'hFFFF);

        // full scale index saturates to the last entry
        configure(16'd0, 16'hFFFF, 64'd65537, 1'b1, 1'b1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);

        for (int phase = 0; phase < 5; phase++)
        begin
            random_config();
            calm = (phase == 4);
            tx_idle_pct = (phase == 0 || $urandom_range(1)) ? 25 : 0;
            rx_idle_pct = (phase == 0 || $urandom_range(1)) ? 20 : 0;
            if (phase == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 100; k++)
            begin
                if (phase == 2 && k == 50)
                    wait_drained();
                if ($urandom_range(99) < 15)
                    send_entry(TIDX_W'($urandom), GRAY_W'($urandom));
                else
                    send_pixel(pick_depth());
            end
        end

        wait_drained();
        if (mismatches == 0 && gray_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dwg_pkg.sv
sv/dwg_cfg.sv
sv/dwg_norm.sv
sv/dwg_map.sv
sv/depth_window_to_gray_gamma.sv
tb/sv/gray_level_checker.sv
tb/sv/depth_window_to_gray_gamma_test.sv
